### hdl/gbm_pkg.sv
// Shared types, constants and tables for the GBM price path stepper.
// Used by the queue, the front and back parts, and the top level.
package gbm_pkg;

	localparam int QDEPTH = 2;
	localparam int QPTR_W = $clog2(QDEPTH);

	localparam logic [30:0] LOG2E_Q30 = 31'd1549082005;
	localparam logic [29:0] LN2_Q30 = 30'd744261118;
	localparam logic [31:0] ONE_Q30 = 32'd1073741824;
	localparam logic [31:0] PRICE_MAX = 32'hFFFF_FFFF;
	localparam logic [3:0] HORNER_TERMS = 4'd12;

	localparam logic [2:0] REG_DRIFT = 3'd0;
	localparam logic [2:0] REG_VOL = 3'd1;
	localparam logic [2:0] REG_SPOT = 3'd2;
	localparam logic [2:0] REG_STEPS = 3'd3;
	localparam logic [2:0] REG_PATHS = 3'd4;
	localparam logic [2:0] REG_ANTI = 3'd5;

	typedef struct packed {
		logic signed [31:0] drift_step;
		logic [23:0] vol_step;
		logic [31:0] spot_price;
		logic [15:0] steps_per_path;
		logic [15:0] path_count;
		logic antithetic_mode;
	} cfg_t;

	typedef struct packed {
		logic is_spot;
		logic signed [31:0] log_main;
		logic signed [31:0] log_mirror;
		logic [15:0] idx;
		logic pe;
		logic be;
	} entry_t;

	typedef enum logic [1:0] {F_IDLE, F_MUL, F_ADD, F_PUSH} front_state_t;
	typedef enum logic [1:0] {FP_SPOT, FP_STEP} push_sel_t;
	typedef enum logic [3:0] {
		B_IDLE, B_Y, B_T, B_HMUL, B_HREC, B_HCOR, B_PMUL, B_SHIFT, B_OUT
	} back_state_t;

	// floor(2^35 / n) for the Horner divisors; n of one is bypassed.
	function automatic logic [34:0] recip(input logic [3:0] n);
		logic [34:0] r;
		case (n)
			4'd2: r = 35'd17179869184;
			4'd3: r = 35'd11453246122;
			4'd4: r = 35'd8589934592;
			4'd5: r = 35'd6871947673;
			4'd6: r = 35'd5726623061;
			4'd7: r = 35'd4908534052;
			4'd8: r = 35'd4294967296;
			4'd9: r = 35'd3817748707;
			4'd10: r = 35'd3435973836;
			4'd11: r = 35'd3123612578;
			4'd12: r = 35'd2863311530;
			default: r = 35'd0;
		endcase
		return r;
	endfunction

endpackage

### hdl/gbm_queue.sv
// Two-entry register queue between the front and back parts.
// Depends on gbm_pkg for the entry type and depth.
module gbm_queue (
	input logic clk,
	input logic arst_n,
	input logic push,
	input gbm_pkg::entry_t push_data,
	output logic full,
	input logic pop,
	output logic empty,
	output gbm_pkg::entry_t pop_data
);
	import gbm_pkg::*;

	entry_t mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_q, rd_q;
	logic [QPTR_W:0] cnt_q;

	assign full = (cnt_q == (QPTR_W+1)'(QDEPTH));
	assign empty = (cnt_q == '0);
	assign pop_data = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push && !full) begin
			mem_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push && !full) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop && !empty) begin
				rd_q <= rd_q + 1'b1;
			end
			cnt_q <= cnt_q + (QPTR_W+1)'(push && !full) - (QPTR_W+1)'(pop && !empty);
		end
	end
endmodule

### hdl/gbm_front.sv
// Front part: takes samples, updates both log offsets and the step and
// path counters, and queues a spot entry and a step entry. Uses gbm_pkg.
module gbm_front (
	input logic clk,
	input logic arst_n,
	input gbm_pkg::cfg_t cfg,
	input logic in_valid,
	output logic in_stall,
	input logic signed [15:0] normal_sample,
	output logic push,
	output gbm_pkg::entry_t push_data,
	input logic full
);
	import gbm_pkg::*;

	front_state_t state_q, state_d;
	push_sel_t sel_q;
	logic signed [15:0] sample_q;
	logic first_q;
	logic signed [32:0] noise_q;
	logic signed [31:0] log_main_q, log_mirror_q;
	logic [15:0] step_q, path_q;
	entry_t ent_q, spot_ent;

	logic signed [40:0] nprod;
	logic signed [34:0] sum_m, sum_r, base_m, base_r;
	logic [15:0] steps, paths, idx, pnext;
	logic pe, be;

	function automatic logic signed [31:0] sat32(input logic signed [34:0] v);
		logic signed [31:0] r;
		if (v > 35'sd2147483647) begin
			r = 32'sh7FFF_FFFF;
		end else if (v < -35'sd2147483648) begin
			r = 32'sh8000_0000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

	// The product is formed from the held sample, since the port may already
	// carry the next item.
	always_comb begin
		nprod = $signed({17'b0, cfg.vol_step}) * 41'(sample_q);
		base_m = first_q ? 35'sd0 : 35'(log_main_q);
		base_r = first_q ? 35'sd0 : 35'(log_mirror_q);
		sum_m = base_m + 35'(cfg.drift_step) + 35'(noise_q);
		sum_r = base_r + 35'(cfg.drift_step) - 35'(noise_q);
		steps = (cfg.steps_per_path == '0) ? 16'd1 : cfg.steps_per_path;
		paths = (cfg.path_count == '0) ? 16'd1 : cfg.path_count;
		idx = step_q + 16'd1;
		pe = (idx >= steps) || (idx == '0);
		pnext = path_q + 16'd1;
		be = pe && ((pnext >= paths) || (pnext == '0));
		spot_ent = '{is_spot: 1'b1, log_main: '0, log_mirror: '0, idx: '0,
			pe: 1'b0, be: 1'b0};
	end

	always_comb begin
		state_d = state_q;
		in_stall = 1'b1;
		push = 1'b0;
		push_data = (sel_q == FP_SPOT) ? spot_ent : ent_q;
		case (state_q)
			F_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					state_d = F_MUL;
				end
			end
			F_MUL: state_d = F_ADD;
			F_ADD: state_d = F_PUSH;
			F_PUSH: begin
				push = 1'b1;
				if (!full && sel_q == FP_STEP) begin
					state_d = F_IDLE;
				end
			end
			default: state_d = F_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			sel_q <= FP_STEP;
			first_q <= 1'b0;
			log_main_q <= '0;
			log_mirror_q <= '0;
			step_q <= '0;
			path_q <= '0;
		end else begin
			state_q <= state_d;
			case (state_q)
				F_IDLE: begin
					if (in_valid) begin
						first_q <= (step_q == '0);
					end
				end
				F_ADD: begin
					log_main_q <= sat32(sum_m);
					log_mirror_q <= sat32(sum_r);
					sel_q <= first_q ? FP_SPOT : FP_STEP;
					if (pe) begin
						step_q <= '0;
						path_q <= be ? 16'd0 : pnext;
					end else begin
						step_q <= idx;
					end
				end
				F_PUSH: begin
					if (!full) begin
						sel_q <= FP_STEP;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == F_IDLE && in_valid) begin
			sample_q <= normal_sample;
		end
		if (state_q == F_MUL) begin
			noise_q <= 33'(nprod >>> 8);
		end
		if (state_q == F_ADD) begin
			ent_q <= '{is_spot: 1'b0, log_main: sat32(sum_m), log_mirror: sat32(sum_r),
				idx: idx, pe: pe, be: be};
		end
	end
endmodule

### hdl/gbm_back.sv
// Back part: turns each queued log offset into spot * exp(offset) with a
// 12-term Horner series. Uses gbm_pkg.
module gbm_back (
	input logic clk,
	input logic arst_n,
	input gbm_pkg::cfg_t cfg,
	input logic empty,
	input gbm_pkg::entry_t pop_data,
	output logic pop,
	output logic out_valid,
	input logic out_stall,
	output logic [31:0] price_main,
	output logic [31:0] price_mirror,
	output logic [15:0] step_index,
	output logic path_end,
	output logic batch_end
);
	import gbm_pkg::*;

	back_state_t state_q, state_d;
	entry_t ent_q;
	logic mirror_q;
	logic signed [32:0] y_q;
	logic signed [6:0] k_q;
	logic [29:0] t_q;
	logic [31:0] acc_q, v_q, q0_q;
	logic [3:0] n_q;
	logic [63:0] prod_q;
	logic [31:0] pm_q, pr_q;

	logic signed [31:0] x;
	logic signed [63:0] yprod;
	logic [55:0] tprod;
	logic [61:0] hprod;
	logic [66:0] rprod;
	logic [35:0] rem;
	logic [31:0] q;
	logic signed [7:0] s;
	logic [5:0] sh;
	logic [63:0] rshift;
	logic [95:0] lshift;
	logic [31:0] price;

	always_comb begin
		x = mirror_q ? ent_q.log_mirror : ent_q.log_main;
		yprod = 64'(x) * $signed({33'b0, LOG2E_Q30});
		tprod = 56'(y_q[25:0]) * 56'(LN2_Q30);
		hprod = 62'(acc_q) * 62'(t_q);
		rprod = 67'(v_q) * 67'(recip(n_q));
		rem = 36'(v_q) - 36'(q0_q) * 36'(n_q);
		if (n_q == 4'd1) begin
			q = v_q;
		end else if (rem >= 36'(n_q)) begin
			q = q0_q + 32'd1;
		end else begin
			q = q0_q;
		end
		s = 8'sd30 - 8'(k_q);
		sh = s[7] ? 6'(-s) : s[5:0];
		rshift = prod_q >> sh;
		lshift = {32'b0, prod_q} << sh;
		if (!s[7]) begin
			if (s >= 8'sd64) begin
				price = '0;
			end else if (rshift[63:32] != '0) begin
				price = PRICE_MAX;
			end else begin
				price = rshift[31:0];
			end
		end else if (prod_q == '0) begin
			price = '0;
		end else if (sh >= 6'd32 || lshift[95:32] != '0) begin
			price = PRICE_MAX;
		end else begin
			price = lshift[31:0];
		end
	end

	always_comb begin
		state_d = state_q;
		pop = 1'b0;
		case (state_q)
			B_IDLE: begin
				if (!empty) begin
					pop = 1'b1;
					state_d = pop_data.is_spot ? B_OUT : B_Y;
				end
			end
			B_Y: state_d = B_T;
			B_T: state_d = B_HMUL;
			B_HMUL: state_d = B_HREC;
			B_HREC: state_d = B_HCOR;
			B_HCOR: state_d = (n_q == 4'd1) ? B_PMUL : B_HMUL;
			B_PMUL: state_d = B_SHIFT;
			B_SHIFT: state_d = (!mirror_q && cfg.antithetic_mode) ? B_Y : B_OUT;
			B_OUT: begin
				if (!out_stall) begin
					state_d = B_IDLE;
				end
			end
			default: state_d = B_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			B_IDLE: begin
				ent_q <= pop_data;
				mirror_q <= 1'b0;
				pm_q <= cfg.spot_price;
				pr_q <= cfg.antithetic_mode ? cfg.spot_price : 32'd0;
			end
			B_Y: y_q <= 33'(yprod >>> 30);
			B_T: begin
				k_q <= y_q[32:26];
				t_q <= tprod[55:26];
				acc_q <= ONE_Q30;
				n_q <= HORNER_TERMS;
			end
			B_HMUL: v_q <= hprod[61:30];
			B_HREC: q0_q <= rprod[66:35];
			B_HCOR: begin
				acc_q <= ONE_Q30 + q;
				n_q <= n_q - 4'd1;
			end
			B_PMUL: prod_q <= 64'(cfg.spot_price) * 64'(acc_q);
			B_SHIFT: begin
				if (mirror_q) begin
					pr_q <= price;
				end else begin
					pm_q <= price;
					pr_q <= '0;
				end
				mirror_q <= 1'b1;
			end
			default: ;
		endcase
	end

	assign out_valid = (state_q == B_OUT);
	assign price_main = pm_q;
	assign price_mirror = pr_q;
	assign step_index = ent_q.idx;
	assign path_end = ent_q.pe;
	assign batch_end = ent_q.be;
endmodule

### hdl/gbm_price_path_stepper_core.sv
// GBM price path stepper: one normal sample in, one or two price points out.
// The front takes one sample at a time and queues its step point, on a path
// start after the spot point. The back part pops an entry, computes its price
// with a 12-term Horner series (twice with mirror on) and presents it; spot
// entries skip the series. Neither part takes a new item before the last is
// queued or presented.
// Async active-low reset clears counters, offsets and the queue; the
// registers return to drift 0, vol 0, spot 1.0, 256 steps, 1 path, mirror off.
module gbm_price_path_stepper_core (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [2:0] cfg_index,
	input logic [31:0] cfg_data,
	input logic in_valid,
	output logic in_stall,
	input logic signed [15:0] normal_sample,
	output logic out_valid,
	input logic out_stall,
	output logic [31:0] price_main,
	output logic [31:0] price_mirror,
	output logic [15:0] step_index,
	output logic path_end,
	output logic batch_end
);
	import gbm_pkg::*;

	cfg_t cfg_q;
	entry_t q_in, q_out;
	logic q_push, q_full, q_pop, q_empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{drift_step: '0, vol_step: '0, spot_price: 32'd65536,
				steps_per_path: 16'd256, path_count: 16'd1, antithetic_mode: 1'b0};
		end else if (cfg_we) begin
			case (cfg_index)
				REG_DRIFT: cfg_q.drift_step <= cfg_data;
				REG_VOL: cfg_q.vol_step <= cfg_data[23:0];
				REG_SPOT: cfg_q.spot_price <= cfg_data;
				REG_STEPS: cfg_q.steps_per_path <= cfg_data[15:0];
				REG_PATHS: cfg_q.path_count <= cfg_data[15:0];
				REG_ANTI: cfg_q.antithetic_mode <= cfg_data[0];
				default: ;
			endcase
		end
	end

	gbm_front u_front (
		.clk(clk), .arst_n(arst_n), .cfg(cfg_q),
		.in_valid(in_valid), .in_stall(in_stall), .normal_sample(normal_sample),
		.push(q_push), .push_data(q_in), .full(q_full)
	);

	gbm_queue u_queue (
		.clk(clk), .arst_n(arst_n),
		.push(q_push), .push_data(q_in), .full(q_full),
		.pop(q_pop), .empty(q_empty), .pop_data(q_out)
	);

	gbm_back u_back (
		.clk(clk), .arst_n(arst_n), .cfg(cfg_q),
		.empty(q_empty), .pop_data(q_out), .pop(q_pop),
		.out_valid(out_valid), .out_stall(out_stall),
		.price_main(price_main), .price_mirror(price_mirror),
		.step_index(step_index), .path_end(path_end), .batch_end(batch_end)
	);

	// A batch always closes on the last point of a path.
	a_batch_in_path: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && batch_end |-> path_end)
		else $error("batch end without path end");

	// The back part only takes an item from the queue when one is waiting.
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_empty)
		else $error("queue popped while empty");

	// A spot entry is always reported as step zero with no end flags.
	a_spot_flags: assert property (@(posedge clk) disable iff (!arst_n)
		q_push && q_in.is_spot |-> q_in.idx == '0 && !q_in.pe && !q_in.be)
		else $error("spot entry carries step flags");
endmodule
